[sv/sprle_pkg.sv]
// ----------------------------------------------------------------------------
// sprle_pkg
// shared widths, register indexes, reset values and code limits for the
// subpicture run-length line decoder
// ----------------------------------------------------------------------------
`default_nettype none

package sprle_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int BYTE_W         = 8;
  localparam int NIB_W          = 4;
  localparam int CODE_W         = 16;
  localparam int HELD_W         = 2;
  localparam int GRAY_W         = 8;
  localparam int ALPHA_W        = 8;

  localparam int LINE_WIDTH_W   = 13;
  localparam int LINE_COUNT_W   = 12;
  localparam int GRAY_MAP_W     = 32;
  localparam int CONTRAST_MAP_W = 16;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_IDX_W      = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_LINE_COUNT   = 2'd1,
    REG_GRAY_MAP     = 2'd2,
    REG_CONTRAST_MAP = 2'd3
  } cfg_reg_e;

  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 13'd720;
  localparam logic [LINE_COUNT_W-1:0]   LINE_COUNT_RST   = 12'd576;
  localparam logic [GRAY_MAP_W-1:0]     GRAY_MAP_RST     = 32'h0000_0000;
  localparam logic [CONTRAST_MAP_W-1:0] CONTRAST_MAP_RST = 16'h0000;

  // smallest complete code of one, two and three nibbles
  localparam logic [CODE_W-1:0] CODE_MIN_1 = 16'h0004;
  localparam logic [CODE_W-1:0] CODE_MIN_2 = 16'h0010;
  localparam logic [CODE_W-1:0] CODE_MIN_3 = 16'h0040;

  typedef struct packed {
    logic [GRAY_MAP_W-1:0]     gray_map;
    logic [CONTRAST_MAP_W-1:0] contrast_map;
    logic [LINE_COUNT_W-1:0]   line_count;
  } cfg_t;

endpackage

`default_nettype wire

[sv/sprle_cfg.sv]
// ----------------------------------------------------------------------------
// sprle_cfg
// configuration registers and clamped line width
// ----------------------------------------------------------------------------
`default_nettype none

module sprle_cfg #(
  parameter int CoordBits = sprle_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [sprle_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sprle_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output sprle_pkg::cfg_t                       cfg_o,
  output logic [CoordBits:0]                    width_o
);
  import sprle_pkg::*;

  localparam int LwW = (CoordBits + 1 > LINE_WIDTH_W) ? CoordBits + 1 : LINE_WIDTH_W;

  logic [LINE_WIDTH_W-1:0]   line_width_q;
  logic [LINE_COUNT_W-1:0]   line_count_q;
  logic [GRAY_MAP_W-1:0]     gray_map_q;
  logic [CONTRAST_MAP_W-1:0] contrast_map_q;
  logic [LwW-1:0]            lw_ext;
  logic [LwW-1:0]            max_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LINE_WIDTH_RST;
      line_count_q   <= LINE_COUNT_RST;
      gray_map_q     <= GRAY_MAP_RST;
      contrast_map_q <= CONTRAST_MAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_LINE_WIDTH:   line_width_q   <= cfg_wdata_i[LINE_WIDTH_W-1:0];
        REG_LINE_COUNT:   line_count_q   <= cfg_wdata_i[LINE_COUNT_W-1:0];
        REG_GRAY_MAP:     gray_map_q     <= cfg_wdata_i[GRAY_MAP_W-1:0];
        REG_CONTRAST_MAP: contrast_map_q <= cfg_wdata_i[CONTRAST_MAP_W-1:0];
        default:          line_width_q   <= line_width_q;
      endcase
    end
  end

  // zero counts as one, oversize clamps to the full coordinate range
  assign lw_ext  = LwW'(line_width_q);
  assign max_ext = LwW'(1) << CoordBits;

  always_comb begin
    if (lw_ext == '0) begin
      width_o = (CoordBits + 1)'(1);
    end else if (lw_ext > max_ext) begin
      width_o = max_ext[CoordBits:0];
    end else begin
      width_o = lw_ext[CoordBits:0];
    end
  end

  assign cfg_o.gray_map     = gray_map_q;
  assign cfg_o.contrast_map = contrast_map_q;
  assign cfg_o.line_count   = line_count_q;

endmodule

`default_nettype wire

[sv/sprle_nibble.sv]
// ----------------------------------------------------------------------------
// sprle_nibble
// one nibble step: code gathering, run length clip, position update
// ----------------------------------------------------------------------------
`default_nettype none

module sprle_nibble #(
  parameter int CoordBits = sprle_pkg::COORD_BITS_DEF
) (
  input  wire logic [sprle_pkg::NIB_W-1:0]  nib_i,
  input  wire logic [CoordBits-1:0]         col_i,
  input  wire logic [CoordBits-1:0]         row_i,
  input  wire logic [sprle_pkg::CODE_W-1:0] acc_i,
  input  wire logic [sprle_pkg::HELD_W-1:0] held_i,
  input  wire logic [CoordBits:0]           width_i,
  input  sprle_pkg::cfg_t                   cfg_i,
  output logic                              emit_o,
  output logic                              ends_o,
  output logic                              fin_set_o,
  output logic [CoordBits:0]                len_o,
  output logic [sprle_pkg::GRAY_W-1:0]      gray_o,
  output logic [sprle_pkg::ALPHA_W-1:0]     alpha_o,
  output logic [CoordBits-1:0]              col_o,
  output logic [CoordBits-1:0]              row_o,
  output logic [sprle_pkg::CODE_W-1:0]      acc_o,
  output logic [sprle_pkg::HELD_W-1:0]      held_o
);
  import sprle_pkg::*;

  localparam int RawW = CODE_W - 2;
  localparam int LenW = (CoordBits + 1 > RawW) ? CoordBits + 1 : RawW;
  localparam int CmpW = (CoordBits > LINE_COUNT_W) ? CoordBits : LINE_COUNT_W;

  logic [CODE_W-1:0]    code;
  logic                 done;
  logic [1:0]           color;
  logic [RawW-1:0]      len_raw;
  logic [CoordBits:0]   col_ext;
  logic [CoordBits:0]   left;
  logic [CoordBits:0]   len_eff;
  logic [CoordBits+1:0] sum;
  logic [CoordBits-1:0] row_inc;

  assign code = {acc_i[CODE_W-NIB_W-1:0], nib_i};

  always_comb begin
    unique case (held_i)
      2'd0:    done = (code >= CODE_MIN_1);
      2'd1:    done = (code >= CODE_MIN_2);
      2'd2:    done = (code >= CODE_MIN_3);
      default: done = 1'b1;
    endcase
  end

  assign color   = ~code[1:0];
  assign len_raw = code[CODE_W-1:2];
  assign col_ext = {1'b0, col_i};
  assign left    = (col_ext < width_i) ? (width_i - col_ext) : (CoordBits + 1)'(1);

  // zero or overlong run fills to end of line
  assign len_eff = ((len_raw == '0) || (LenW'(len_raw) > LenW'(left))) ?
                   left : (CoordBits + 1)'(LenW'(len_raw));

  assign sum     = (CoordBits + 2)'(col_i) + (CoordBits + 2)'(len_eff);
  assign row_inc = row_i + CoordBits'(1);

  assign emit_o    = done;
  assign ends_o    = done && (sum >= (CoordBits + 2)'(width_i));
  assign fin_set_o = ends_o && (CmpW'(row_inc) >= CmpW'(cfg_i.line_count));
  assign len_o     = len_eff;
  assign gray_o    = cfg_i.gray_map[{color, 3'b000} +: GRAY_W];
  assign alpha_o   = {cfg_i.contrast_map[{code[1:0], 2'b00} +: NIB_W], 4'h0};

  assign col_o  = !done ? col_i : (ends_o ? '0 : sum[CoordBits-1:0]);
  assign row_o  = ends_o ? row_inc : row_i;
  assign acc_o  = done ? '0 : code;
  assign held_o = done ? '0 : held_i + HELD_W'(1);

endmodule

`default_nettype wire

[sv/subpicture_rle_line_decoder.sv]
// ----------------------------------------------------------------------------
// subpicture_rle_line_decoder
// run-length line decoder for subpicture pixel data, one run per result
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  cfg     | in        | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//  in      | in        | in_valid_i/in_stall_o | rle_byte_i, new_image_i
//  out     | out       | out_valid_o/out_stall_i | run_row_o .. last_result_o
//
//  the nibble unit takes one nibble per cycle while the result register is
//  not stalled; the low nibble is skipped when the high one ends a line, the
//  whole byte when the image is already done; a new byte is taken while the
//  previous one finishes; the result register holds one run and the nibble
//  unit waits while it is stalled; reset clears position, partial code and
//  handshake state; line width 720, line count 576, both maps zero
// ----------------------------------------------------------------------------
`default_nettype none

module subpicture_rle_line_decoder #(
  parameter int CoordBits = sprle_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [sprle_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sprle_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [sprle_pkg::BYTE_W-1:0]     rle_byte_i,
  input  wire logic                             new_image_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [CoordBits-1:0]                  run_row_o,
  output logic [CoordBits-1:0]                  run_start_o,
  output logic [CoordBits:0]                    run_length_o,
  output logic [sprle_pkg::GRAY_W-1:0]          run_gray_o,
  output logic [sprle_pkg::ALPHA_W-1:0]         run_alpha_o,
  output logic                                  line_end_o,
  output logic                                  image_end_o,
  output logic                                  last_result_o
);
  import sprle_pkg::*;

  localparam int CmpW = (CoordBits > LINE_COUNT_W) ? CoordBits : LINE_COUNT_W;

  cfg_t                 cfg;
  logic [CoordBits:0]   width;

  // request held in the input register
  logic                 in_valid_q;
  logic [BYTE_W-1:0]    byte_q;
  logic                 new_image_q;
  logic                 phase_q;

  // decoder state
  logic [CoordBits-1:0] col_q, col_d;
  logic [CoordBits-1:0] row_q, row_d;
  logic [CODE_W-1:0]    acc_q, acc_d;
  logic [HELD_W-1:0]    held_q, held_d;
  logic                 fin_q, fin_d;

  // state seen by the current step
  logic [CoordBits-1:0] col_c, row_c;
  logic [CODE_W-1:0]    acc_c;
  logic [HELD_W-1:0]    held_c;
  logic                 fin_c;
  logic                 clear;
  logic                 drop;
  logic [NIB_W-1:0]     nib;

  logic                 emit, ends, fin_set;
  logic [CoordBits:0]   len;
  logic [GRAY_W-1:0]    gray;
  logic [ALPHA_W-1:0]   alpha;
  logic [CoordBits-1:0] col_n, row_n;
  logic [CODE_W-1:0]    acc_n;
  logic [HELD_W-1:0]    held_n;

  logic                 step;
  logic                 finish;
  logic                 last;
  logic                 in_accept;
  logic                 out_load;

  sprle_cfg #(
    .CoordBits(CoordBits)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .width_o     (width)
  );

  assign clear  = new_image_q && !phase_q;
  assign col_c  = clear ? '0 : col_q;
  assign row_c  = clear ? '0 : row_q;
  assign acc_c  = clear ? '0 : acc_q;
  assign held_c = clear ? '0 : held_q;
  assign fin_c  = clear ? 1'b0 : fin_q;
  assign drop   = !phase_q && (fin_c || (CmpW'(row_c) >= CmpW'(cfg.line_count)));
  assign nib    = phase_q ? byte_q[NIB_W-1:0] : byte_q[BYTE_W-1:NIB_W];

  sprle_nibble #(
    .CoordBits(CoordBits)
  ) u_nibble (
    .nib_i     (nib),
    .col_i     (col_c),
    .row_i     (row_c),
    .acc_i     (acc_c),
    .held_i    (held_c),
    .width_i   (width),
    .cfg_i     (cfg),
    .emit_o    (emit),
    .ends_o    (ends),
    .fin_set_o (fin_set),
    .len_o     (len),
    .gray_o    (gray),
    .alpha_o   (alpha),
    .col_o     (col_n),
    .row_o     (row_n),
    .acc_o     (acc_n),
    .held_o    (held_n)
  );

  assign step      = in_valid_q && (!out_valid_o || !out_stall_i);
  assign finish    = phase_q || drop || ends;
  assign in_stall_o = in_valid_q && !(step && finish);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_load  = step && !drop && emit;

  // after a run from the high nibble, the low nibble alone completes a code
  // only if it is at least the one-nibble minimum
  assign last = phase_q || ends ||
                ({{(CODE_W-NIB_W){1'b0}}, byte_q[NIB_W-1:0]} < CODE_MIN_1);

  always_comb begin
    if (drop) begin
      col_d  = col_c;
      row_d  = row_c;
      acc_d  = acc_c;
      held_d = held_c;
      fin_d  = fin_c;
    end else begin
      col_d  = col_n;
      row_d  = row_n;
      acc_d  = acc_n;
      held_d = held_n;
      fin_d  = fin_c || fin_set;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      acc_q       <= '0;
      held_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (step) begin
        col_q  <= col_d;
        row_q  <= row_d;
        acc_q  <= acc_d;
        held_q <= held_d;
        fin_q  <= fin_d;
      end
      if (in_accept) begin
        in_valid_q <= 1'b1;
        phase_q    <= 1'b0;
      end else if (step && finish) begin
        in_valid_q <= 1'b0;
        phase_q    <= 1'b0;
      end else if (step) begin
        phase_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q      <= rle_byte_i;
      new_image_q <= new_image_i;
    end
    if (out_load) begin
      run_row_o     <= row_c;
      run_start_o   <= col_c;
      run_length_o  <= len;
      run_gray_o    <= gray;
      run_alpha_o   <= alpha;
      line_end_o    <= ends;
      image_end_o   <= fin_set;
      last_result_o <= last;
    end
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the subpicture run-length line decoder; a directed
// table runs first, a few rows with a fixed expected run and the rest checked
// against the bench model, then random phases with new line geometry and color
// maps set while idle and, save in the last, random pauses on both handshakes
// ----------------------------------------------------------------------------

module tb_top;

  import sprle_pkg::*;

  localparam int CB = COORD_BITS_DEF;

  typedef struct packed {
    logic [CB-1:0]      row;
    logic [CB-1:0]      start;
    logic [CB:0]        length;
    logic [GRAY_W-1:0]  gray;
    logic [ALPHA_W-1:0] alpha;
    logic               line_end;
    logic               image_end;
    logic               last_res;
  } run_t;

  typedef enum logic {STEP_BYTE, STEP_CFG} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    cfg_reg_e    idx;
    logic [31:0] val;
    logic [7:0]  b;
    logic        ni;
    bit          pinned;
    run_t        pin;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_reg_e              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     rle_byte_i;
  logic                  new_image_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [CB-1:0]         run_row_o;
  logic [CB-1:0]         run_start_o;
  logic [CB:0]           run_length_o;
  logic [GRAY_W-1:0]     run_gray_o;
  logic [ALPHA_W-1:0]    run_alpha_o;
  logic                  line_end_o;
  logic                  image_end_o;
  logic                  last_result_o;

  subpicture_rle_line_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rle_byte_i    (rle_byte_i),
    .new_image_i   (new_image_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .run_row_o     (run_row_o),
    .run_start_o   (run_start_o),
    .run_length_o  (run_length_o),
    .run_gray_o    (run_gray_o),
    .run_alpha_o   (run_alpha_o),
    .line_end_o    (line_end_o),
    .image_end_o   (image_end_o),
    .last_result_o (last_result_o)
  );

  // decoder model state and register copies
  logic [LINE_WIDTH_W-1:0]   cfg_width;
  logic [LINE_COUNT_W-1:0]   cfg_lines;
  logic [GRAY_MAP_W-1:0]     cfg_gray;
  logic [CONTRAST_MAP_W-1:0] cfg_contrast;
  logic [CB-1:0]             col_q;
  logic [CB-1:0]             row_q;
  logic [CODE_W-1:0]         code_q;
  logic [HELD_W-1:0]         held_q;
  logic                      done_q;

  run_t  runs_due[$];
  step_t steps[$];
  bit    pin_on;
  run_t  pin_run;
  bit    idle_on;
  int    errors;
  int    bytes_taken;
  int    runs_checked;
  int    lines_seen;
  int    images_seen;
  int    settings;

  function automatic bit take_nibble(input logic [3:0] nib, output run_t r);
    logic [CODE_W-1:0]         code;
    logic [CONTRAST_MAP_W-1:0] cmap;
    bit                        fin;
    int unsigned               wd, left, len, color, col;
    r = '0;
    code = {code_q[11:0], nib};
    case (held_q)
      2'd0: fin = code >= CODE_MIN_1;
      2'd1: fin = code >= CODE_MIN_2;
      2'd2: fin = code >= CODE_MIN_3;
      default: fin = 1'b1;
    endcase
    if (!fin) begin
      code_q = code;
      held_q = held_q + 2'd1;
      return 1'b0;
    end
    color = 3 - code[1:0];
    len = code >> 2;
    wd = (cfg_width == 0) ? 1 : ((cfg_width > (1 << CB)) ? (1 << CB) : cfg_width);
    left = (col_q < wd) ? wd - col_q : 1;
    if (len == 0 || len > left) len = left;
    cmap = cfg_contrast >> (12 - 4 * color);
    r.row = row_q;
    r.start = col_q;
    r.length = (CB+1)'(len);
    r.gray = GRAY_W'(cfg_gray >> (8 * color));
    r.alpha = {cmap[3:0], 4'h0};
    code_q = '0;
    held_q = '0;
    col = col_q + len;
    if (col >= wd) begin
      col_q = '0;
      row_q = row_q + CB'(1);
      r.line_end = 1'b1;
      if (row_q >= cfg_lines) begin
        done_q = 1'b1;
        r.image_end = 1'b1;
      end
    end else begin
      col_q = CB'(col);
    end
    return 1'b1;
  endfunction

  function automatic int decode_byte(input logic [7:0] b, input logic ni,
                                     output run_t r0, output run_t r1);
    run_t r;
    int   n;
    n = 0;
    r0 = '0;
    r1 = '0;
    if (ni) begin
      col_q = '0;
      row_q = '0;
      code_q = '0;
      held_q = '0;
      done_q = 1'b0;
    end
    if (done_q || row_q >= cfg_lines) return 0;
    if (take_nibble(b[7:4], r)) begin
      r0 = r;
      n = 1;
    end
    if (!(n == 1 && r0.line_end)) begin
      if (take_nibble(b[3:0], r)) begin
        if (n == 0) r0 = r;
        else r1 = r;
        n++;
      end
    end
    if (n == 1) r0.last_res = 1'b1;
    else if (n == 2) r1.last_res = 1'b1;
    return n;
  endfunction

  function automatic string fmt_run(input run_t r);
    return $sformatf("row %0d start %0d len %0d gray %02h alpha %02h le %0b ie %0b last %0b",
                     r.row, r.start, r.length, r.gray, r.alpha, r.line_end,
                     r.image_end, r.last_res);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : observe
    run_t r0, r1, got, exp;
    int   n;
    if (in_valid_i && in_stall_o === 1'b0) begin
      n = decode_byte(rle_byte_i, new_image_i, r0, r1);
      bytes_taken++;
      if (pin_on) begin
        runs_due.push_back(pin_run);
      end else begin
        if (n > 0) runs_due.push_back(r0);
        if (n > 1) runs_due.push_back(r1);
      end
    end
    if (out_valid_o === 1'b1 && !out_stall_i) begin
      got = {run_row_o, run_start_o, run_length_o, run_gray_o, run_alpha_o,
             line_end_o, image_end_o, last_result_o};
      if (runs_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected run: %s", fmt_run(got));
      end else begin
        exp = runs_due.pop_front();
        runs_checked++;
        if (got !== exp) begin
          errors++;
          if (errors <= 10) begin
            $display("run %0d mismatch, expected %s", runs_checked, fmt_run(exp));
            $display("run %0d mismatch, actual   %s", runs_checked, fmt_run(got));
          end
        end
      end
      if (got.line_end === 1'b1) lines_seen++;
      if (got.image_end === 1'b1) images_seen++;
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic ni, input bit pinned,
                           input run_t pr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rle_byte_i  <= b;
    new_image_i <= ni;
    pin_on      <= pinned;
    pin_run     <= pr;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_LINE_WIDTH:   cfg_width = val[LINE_WIDTH_W-1:0];
      REG_LINE_COUNT:   cfg_lines = val[LINE_COUNT_W-1:0];
      REG_GRAY_MAP:     cfg_gray = val[GRAY_MAP_W-1:0];
      REG_CONTRAST_MAP: cfg_contrast = val[CONTRAST_MAP_W-1:0];
      default: ;
    endcase
    settings++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic tab_byte(input logic [7:0] b, input logic ni);
    steps.push_back('{STEP_BYTE, REG_LINE_WIDTH, 32'd0, b, ni, 1'b0, '0});
  endtask

  task automatic tab_pin(input logic [7:0] b, input logic ni, input int row,
                         input int start, input int len, input logic [7:0] gray,
                         input logic [7:0] alpha, input logic le, input logic ie);
    run_t r;
    r = {CB'(row), CB'(start), (CB+1)'(len), gray, alpha, le, ie, 1'b1};
    steps.push_back('{STEP_BYTE, REG_LINE_WIDTH, 32'd0, b, ni, 1'b1, r});
  endtask

  task automatic tab_cfg(input cfg_reg_e idx, input logic [31:0] val);
    steps.push_back('{STEP_CFG, idx, val, 8'd0, 1'b0, 1'b0, '0});
  endtask

  initial begin : stimulus
    logic [31:0] w, l, g, c;
    logic [7:0]  b;
    logic        ni;
    bit          stuck;
    int          target, counted, issued;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_LINE_WIDTH;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    rle_byte_i  = '0;
    new_image_i = 1'b0;
    pin_on      = 1'b0;
    pin_run     = '0;
    idle_on     = 1'b1;
    cfg_width    = LINE_WIDTH_RST;
    cfg_lines    = LINE_COUNT_RST;
    cfg_gray     = GRAY_MAP_RST;
    cfg_contrast = CONTRAST_MAP_RST;
    col_q  = '0;
    row_q  = '0;
    code_q = '0;
    held_q = '0;
    done_q = 1'b0;

    // reset values: four zero nibbles fill the line, then short codes
    tab_byte(8'h00, 1'b1);
    tab_pin(8'h00, 1'b0, 0, 0, 720, 8'h00, 8'h00, 1'b1, 1'b0);
    tab_pin(8'h41, 1'b0, 1, 0, 1, 8'h00, 8'h00, 1'b0, 1'b0);
    tab_pin(8'h23, 1'b0, 1, 1, 4, 8'h00, 8'h00, 1'b0, 1'b0);
    tab_byte(8'hff, 1'b0);
    tab_byte(8'h03, 1'b0);
    tab_byte(8'hff, 1'b0);
    tab_byte(8'h05, 1'b0);
    tab_byte(8'h5a, 1'b0);
    // oversized width is clamped, two lines then the image is done
    tab_cfg(REG_GRAY_MAP, 32'h1122_3344);
    tab_cfg(REG_CONTRAST_MAP, 32'h0000_f5a0);
    tab_cfg(REG_LINE_WIDTH, 32'd8191);
    tab_cfg(REG_LINE_COUNT, 32'd2);
    tab_byte(8'h00, 1'b1);
    tab_pin(8'h00, 1'b0, 0, 0, 4096, 8'h11, 8'h00, 1'b1, 1'b0);
    tab_byte(8'hfc, 1'b0);
    tab_byte(8'h00, 1'b0);
    tab_pin(8'h00, 1'b0, 1, 6, 4090, 8'h11, 8'h00, 1'b1, 1'b1);
    tab_byte(8'h44, 1'b0);
    // zero width counts as one pixel, rest of the byte dropped
    tab_cfg(REG_LINE_WIDTH, 32'd0);
    tab_cfg(REG_LINE_COUNT, 32'd4095);
    tab_pin(8'h4f, 1'b1, 0, 0, 1, 8'h11, 8'h00, 1'b1, 1'b0);
    tab_byte(8'hff, 1'b0);
    // width lowered below the current column
    tab_cfg(REG_LINE_WIDTH, 32'd16);
    tab_cfg(REG_LINE_COUNT, 32'd3);
    tab_cfg(REG_GRAY_MAP, 32'ha5c3_0ff0);
    tab_cfg(REG_CONTRAST_MAP, 32'h0000_1234);
    tab_byte(8'hff, 1'b1);
    tab_cfg(REG_LINE_WIDTH, 32'd4);
    tab_pin(8'hd1, 1'b0, 0, 6, 1, 8'hc3, 8'h30, 1'b1, 1'b0);
    tab_byte(8'h11, 1'b0);
    tab_byte(8'h3c, 1'b1);
    // new image in the middle of a code
    tab_byte(8'h00, 1'b0);
    tab_byte(8'h80, 1'b1);
    tab_byte(8'h00, 1'b0);
    tab_byte(8'h0f, 1'b0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (steps[i]) begin
      if (steps[i].kind == STEP_CFG) write_reg(steps[i].idx, steps[i].val);
      else send_byte(steps[i].b, steps[i].ni, steps[i].pinned, steps[i].pin);
    end

    for (int ph = 0; ph < 12; ph++) begin
      g = $urandom();
      c = $urandom_range(0, 65535);
      case (ph)
        0: begin w = 720; l = 576; end
        1: begin w = 1; l = $urandom_range(1, 8); end
        2: begin w = 4096; l = 4095; g = 32'hffff_ffff; c = 32'h0000_ffff; end
        3: begin w = 8191; l = 2; g = '0; c = '0; end
        4: begin w = 0; l = 0; end
        default: begin
          w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 40);
          l = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 12);
        end
      endcase
      write_reg(REG_LINE_WIDTH, w);
      write_reg(REG_LINE_COUNT, l);
      write_reg(REG_GRAY_MAP, g);
      write_reg(REG_CONTRAST_MAP, c);
      if (ph == 11) idle_on = 1'b0;
      target = (ph == 4) ? 20 : 120;
      counted = 0;
      issued = 0;
      while (counted < target && issued < 2 * target) begin
        stuck = done_q || row_q >= cfg_lines;
        if (issued == 0) ni = 1'b1;
        else if (stuck) ni = 1'($urandom_range(0, 1));
        else ni = ($urandom_range(0, 39) == 0);
        // bias toward leading zero nibbles for long codes and line fills
        if ($urandom_range(0, 3) == 0) b = {2'b00, 2'($urandom_range(0, 3)),
                                            4'($urandom_range(0, 15))};
        else b = 8'($urandom_range(0, 255));
        if (ni || !stuck) counted++;
        issued++;
        send_byte(b, ni, 1'b0, '0);
        if (ph == 6 && issued == 50) drain();
      end
    end

    drain();
    $display("%0d bytes taken under %0d register writes, %0d runs checked",
             bytes_taken, settings, runs_checked);
    $display("%0d line ends and %0d image ends seen, %0d mismatches",
             lines_seen, images_seen, errors);
    if (errors == 0 && runs_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
